### src/upwind_advection_stencil_top_assert.svh
// Assertion macros for the upwind advection stencil.
// Included by upwind_advection_stencil_top.sv; needs nothing else.
`ifndef UPWIND_ADVECTION_STENCIL_TOP_ASSERT_SVH
`define UPWIND_ADVECTION_STENCIL_TOP_ASSERT_SVH

// same-cycle implication
`define UAS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("uas assertion failed");

// next-cycle implication
`define UAS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("uas assertion failed");

`endif

### src/uas_pkg.sv
// Shared constants and types for the upwind advection stencil.
// No dependencies; used by the top level and uas_mac_cell.
package uas_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam int CELL_W     = 16;   // Q8.8 cell
    localparam int COEF_W     = 18;   // Q1.17 coefficient
    localparam int SIZE_W     = 7;
    localparam int DIFF_W     = CELL_W + 1;
    localparam int PROD_W     = COEF_W + DIFF_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int ROUND_W    = ACC_W + 3;
    localparam int N_TERMS    = 4;
    localparam int OUT_DEPTH  = 8;    // output queue words
    localparam int FRAC_SHIFT = 17;
    localparam int HALF_LSB   = 65536;
    localparam int CELL_MAX   = 32767;
    localparam int CELL_MIN   = -32768;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COEF_W;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_X_POS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_X_NEG = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_Y_POS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_Y_NEG = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 3'd5;

    // One word moving down the multiply-accumulate chain.
    typedef struct packed {
        logic                                 valid;
        logic                                 last;
        logic signed [CELL_W-1:0]             u;
        logic [N_TERMS-1:0][DIFF_W-1:0]       diff;
        logic signed [ACC_W-1:0]              acc;
    } lane_t;

endpackage

### src/upwind_advection_stencil_top.sv
// Upwind advection stencil, top level. Cells of a ghost-padded block come in
// raster order, one word per clock while s_tready is high; each interior cell
// leaves as one updated Q8.8 word via stage 0, stage 1 and the MAC chain after
// the word below it is taken. Line buffer reads and writes share one RAM with
// two read ports, so the stream sustains one word per cycle while s_tready is
// high. After reset all MAX_WIDTH+2 line buffer entries are zeroed, one per
// cycle, with s_tready low; then s_tready depends on free space in the 8-word
// output queue minus words in the chain; config writes are taken at any time.
// Depends on uas_pkg, uas_ram, uas_mac_cell, uas_out_fifo and the assert header.
`include "upwind_advection_stencil_top_assert.svh"

module upwind_advection_stencil_top #(
    parameter int MAX_WIDTH  = uas_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = uas_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // [15:0] cell_value
    input  logic [0:0]                        s_tuser,   // [0] block_start
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,   // [15:0] new_value
    output logic                              m_tlast,   // block_end
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [uas_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [uas_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int DEPTH   = MAX_WIDTH + 2;
    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = $clog2(MAX_WIDTH + 3);
    localparam int RW      = $clog2(MAX_HEIGHT + 3);
    localparam int CELL_W  = uas_pkg::CELL_W;
    localparam int COEF_W  = uas_pkg::COEF_W;
    localparam int SIZE_W  = uas_pkg::SIZE_W;
    localparam int DIFF_W  = uas_pkg::DIFF_W;
    localparam int RDW     = uas_pkg::ROUND_W;
    localparam int NT      = uas_pkg::N_TERMS;
    localparam int QD      = uas_pkg::OUT_DEPTH;
    localparam int FCW     = $clog2(QD + 1);
    localparam int OW      = $clog2(QD + NT + 3);
    localparam int RAM_W   = 2 * CELL_W;

    // ---------------- configuration ----------------
    logic signed [COEF_W-1:0] coef_xp_reg, coef_xn_reg, coef_yp_reg, coef_yn_reg;
    logic [SIZE_W-1:0]        width_reg, height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_xp_reg <= '0;
            coef_xn_reg <= '0;
            coef_yp_reg <= '0;
            coef_yn_reg <= '0;
            width_reg   <= SIZE_W'(64);
            height_reg  <= SIZE_W'(64);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                uas_pkg::REG_COEF_X_POS: coef_xp_reg <= cfg_data;
                uas_pkg::REG_COEF_X_NEG: coef_xn_reg <= cfg_data;
                uas_pkg::REG_COEF_Y_POS: coef_yp_reg <= cfg_data;
                uas_pkg::REG_COEF_Y_NEG: coef_yn_reg <= cfg_data;
                uas_pkg::REG_WIDTH:      width_reg   <= cfg_data[SIZE_W-1:0];
                uas_pkg::REG_HEIGHT:     height_reg  <= cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    logic [CW-1:0] w_use, w_p1;
    logic [RW-1:0] h_use, h_p1;

    always_comb begin
        if (width_reg < SIZE_W'(2)) begin
            w_use = CW'(2);
        end else if (width_reg > MAX_WIDTH) begin
            w_use = CW'(MAX_WIDTH);
        end else begin
            w_use = CW'(width_reg);
        end
        if (height_reg < SIZE_W'(2)) begin
            h_use = RW'(2);
        end else if (height_reg > MAX_HEIGHT) begin
            h_use = RW'(MAX_HEIGHT);
        end else begin
            h_use = RW'(height_reg);
        end
        w_p1 = w_use + CW'(1);
        h_p1 = h_use + RW'(1);
    end

    // ---------------- line buffer clear after reset ----------------
    logic          clearing_reg;
    logic [AW-1:0] clear_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
        end else if (clearing_reg) begin
            clear_addr_reg <= clear_addr_reg + AW'(1);
            if (clear_addr_reg == AW'(DEPTH - 1)) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // ---------------- stage 0: position and buffer read ----------------
    logic          s_accept;
    logic [CW-1:0] column_count_reg, col_a, col_c, col_n, col_inc;
    logic [RW-1:0] row_count_reg, row_a, row_b, row_c, row_n;
    logic          produce_c, last_c, right_c;
    logic [AW-1:0] raddr_a, raddr_b;

    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        col_a = s_tuser[0] ? '0 : column_count_reg;
        row_a = s_tuser[0] ? '0 : row_count_reg;
        // column beyond the row (size shrank): move to next row
        if (col_a > w_p1) begin
            col_c = '0;
            row_b = row_a + RW'(1);
        end else begin
            col_c = col_a;
            row_b = row_a;
        end
        row_c = (row_b > h_p1) ? '0 : row_b;
        if (col_c >= w_p1) begin
            col_n = '0;
            row_n = (row_c >= h_p1) ? '0 : row_c + RW'(1);
        end else begin
            col_n = col_c + CW'(1);
            row_n = row_c;
        end
        produce_c = (row_c >= RW'(2)) && (col_c != '0) && (col_c <= w_use);
        last_c    = (row_c == h_p1) && (col_c == w_use);
        right_c   = (col_c <= w_use);
        col_inc   = col_c + CW'(1);
        raddr_a   = col_c[AW-1:0];
        raddr_b   = right_c ? col_inc[AW-1:0] : col_c[AW-1:0];
    end

    logic                     s0_valid_reg;
    logic                     s0_res_reg, s0_last_reg, s0_right_reg;
    logic [AW-1:0]            s0_addr_a_reg, s0_addr_b_reg;
    logic signed [CELL_W-1:0] s0_cell_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            s0_valid_reg     <= 1'b0;
        end else begin
            s0_valid_reg <= s_accept;
            if (s_accept) begin
                column_count_reg <= col_n;
                row_count_reg    <= row_n;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s0_res_reg    <= produce_c;
            s0_last_reg   <= last_c;
            s0_right_reg  <= right_c;
            s0_addr_a_reg <= raddr_a;
            s0_addr_b_reg <= raddr_b;
            s0_cell_reg   <= s_tdata;
        end
    end

    // line buffer word: {row above, middle row}
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [RAM_W-1:0] ram_wdata, rdata_a, rdata_b;

    uas_ram #(
        .WIDTH (RAM_W),
        .DEPTH (DEPTH)
    ) u_line_buf (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // write issued in the read cycle is not in the read data: forward it
    logic             fwd_we_reg;
    logic [AW-1:0]    fwd_addr_reg;
    logic [RAM_W-1:0] fwd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_we_reg <= 1'b0;
        end else begin
            fwd_we_reg <= ram_we;
        end
        fwd_addr_reg <= ram_waddr;
        fwd_data_reg <= ram_wdata;
    end

    // ---------------- stage 1: window and differences ----------------
    logic                     hit_a, hit_b;
    logic signed [CELL_W-1:0] mid_a, abv_a, mid_b;
    logic signed [CELL_W-1:0] win0_reg, win1_reg, win2_reg;
    logic signed [CELL_W-1:0] win0_next, win1_next, win2_next;
    uas_pkg::lane_t           lane1_reg, lane1_next;

    always_comb begin
        hit_a = fwd_we_reg && (fwd_addr_reg == s0_addr_a_reg);
        hit_b = fwd_we_reg && (fwd_addr_reg == s0_addr_b_reg);
        mid_a = hit_a ? fwd_data_reg[CELL_W-1:0] : rdata_a[CELL_W-1:0];
        abv_a = hit_a ? fwd_data_reg[RAM_W-1:CELL_W] : rdata_a[RAM_W-1:CELL_W];
        mid_b = hit_b ? fwd_data_reg[CELL_W-1:0] : rdata_b[CELL_W-1:0];

        if (s0_addr_a_reg == '0) begin
            win0_next = '0;
            win1_next = mid_a;
        end else begin
            win0_next = win1_reg;
            win1_next = win2_reg;
        end
        win2_next = s0_right_reg ? mid_b : '0;

        lane1_next.valid   = s0_valid_reg && s0_res_reg;
        lane1_next.last    = s0_last_reg;
        lane1_next.u       = win1_next;
        lane1_next.diff[0] = DIFF_W'(win1_next) - DIFF_W'(win0_next);
        lane1_next.diff[1] = DIFF_W'(win2_next) - DIFF_W'(win1_next);
        lane1_next.diff[2] = DIFF_W'(win1_next) - DIFF_W'(abv_a);
        lane1_next.diff[3] = DIFF_W'(s0_cell_reg) - DIFF_W'(win1_next);
        lane1_next.acc     = '0;

        if (clearing_reg) begin
            ram_we    = 1'b1;
            ram_waddr = clear_addr_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = s0_valid_reg;
            ram_waddr = s0_addr_a_reg;
            ram_wdata = {mid_a, s0_cell_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win0_reg <= '0;
            win1_reg <= '0;
            win2_reg <= '0;
        end else if (s0_valid_reg) begin
            win0_reg <= win0_next;
            win1_reg <= win1_next;
            win2_reg <= win2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane1_reg <= '0;
        end else begin
            lane1_reg <= lane1_next;
        end
    end

    // ---------------- multiply-accumulate chain ----------------
    uas_pkg::lane_t           lane_q [NT+1];
    logic signed [COEF_W-1:0] coef_sel [NT];

    assign lane_q[0]   = lane1_reg;
    assign coef_sel[0] = coef_xp_reg;
    assign coef_sel[1] = coef_xn_reg;
    assign coef_sel[2] = coef_yp_reg;
    assign coef_sel[3] = coef_yn_reg;

    for (genvar k = 0; k < NT; k++) begin : g_cell
        uas_mac_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .coef     (coef_sel[k]),
            .diff     ($signed(lane_q[k].diff[k])),
            .lane_in  (lane_q[k]),
            .lane_out (lane_q[k+1])
        );
    end

    // ---------------- round half up and saturate ----------------
    logic signed [RDW-1:0] u_rnd, v_sum, q_full;
    logic [CELL_W-1:0]     sat_val;

    always_comb begin
        // low bits of u<<17 are zero, so the half LSB is just one set bit
        u_rnd  = (RDW'(lane_q[NT].u) <<< uas_pkg::FRAC_SHIFT) | RDW'(uas_pkg::HALF_LSB);
        v_sum  = u_rnd - RDW'(lane_q[NT].acc);
        q_full = v_sum >>> uas_pkg::FRAC_SHIFT;
        if (q_full > RDW'(uas_pkg::CELL_MAX)) begin
            sat_val = CELL_W'(uas_pkg::CELL_MAX);
        end else if (q_full < RDW'(uas_pkg::CELL_MIN)) begin
            sat_val = CELL_W'(uas_pkg::CELL_MIN);
        end else begin
            sat_val = q_full[CELL_W-1:0];
        end
    end

    // ---------------- output queue and credit ----------------
    logic [CELL_W:0] fifo_out;
    logic [FCW-1:0]  fifo_count;
    logic [NT+1:0]   pend_vec;
    logic [OW-1:0]   occupancy;

    uas_out_fifo #(
        .WIDTH (CELL_W + 1),
        .DEPTH (QD)
    ) u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (lane_q[NT].valid),
        .push_data ({lane_q[NT].last, sat_val}),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (fifo_out),
        .count     (fifo_count)
    );

    assign m_tdata = fifo_out[CELL_W-1:0];
    assign m_tlast = fifo_out[CELL_W];

    // every word still in flight holds a queue slot
    assign pend_vec  = {lane_q[4].valid, lane_q[3].valid, lane_q[2].valid,
                        lane_q[1].valid, lane_q[0].valid, s0_valid_reg && s0_res_reg};
    assign occupancy = OW'(fifo_count) + OW'($countones(pend_vec));
    assign s_tready  = !clearing_reg && (occupancy < OW'(QD));

    // ---------------- assertions ----------------
    `UAS_ASSERT_IMPL(a_queue_no_overflow, aclk, aresetn, lane_q[NT].valid && !(m_tvalid && m_tready), fifo_count < FCW'(QD))
    `UAS_ASSERT_IMPL(a_credit_bound, aclk, aresetn, 1'b1, occupancy <= OW'(QD))
    `UAS_ASSERT_NEXT(a_chain_advances, aclk, aresetn, lane_q[0].valid, lane_q[1].valid)

endmodule

### src/uas_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// Stand-alone; no package needed.
module uas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 66
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // reads return the old contents on an address collision
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### src/uas_mac_cell.sv
// One cell of the multiply-accumulate chain: adds coef*diff to the running sum.
// Depends on uas_pkg (lane_t, widths).
module uas_mac_cell (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic signed [uas_pkg::COEF_W-1:0]      coef,
    input  logic signed [uas_pkg::DIFF_W-1:0]      diff,
    input  uas_pkg::lane_t                         lane_in,
    output uas_pkg::lane_t                         lane_out
);

    localparam int PW = uas_pkg::PROD_W;
    localparam int AW = uas_pkg::ACC_W;

    logic signed [PW-1:0] prod;
    uas_pkg::lane_t       lane_reg;
    uas_pkg::lane_t       lane_next;

    always_comb begin
        prod          = coef * diff;
        lane_next     = lane_in;
        lane_next.acc = lane_in.acc + AW'(prod);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_reg <= '0;
        end else begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

### src/uas_out_fifo.sv
// Output word queue; parts the pipeline from the result channel.
// Stand-alone; no package needed.
module uas_out_fifo #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic [WIDTH-1:0]           out_data,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign count     = count_reg;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule
